FILE: hw/rtl/bbe_pkg.sv
package bbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_CAP = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);      // column position
  localparam int XW    = COL_W + 1;              // effective width, holds MAX_WIDTH
  localparam int WID_W = 11;                     // image_width register field
  localparam int HGT_W = 13;                     // image_height register and row position
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SUM_W = 12;                     // up to 9 * 255
  localparam int CNT_W = 4;                      // up to 9 neighbours
  localparam int NUM_W = 13;                     // 2*sum + cnt
  localparam int DEN_W = CNT_W + 1;              // 2*cnt
  localparam int QBITS = CH_W;
  localparam int QIDX_W = $clog2(QBITS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic              latch;
    logic              shift;
    logic              acc_en;
    logic [1:0]        row;
    logic              div_init;
    logic              div_step;
    logic [QIDX_W-1:0] bit_idx;
    logic              out_load;
  } bbe_cmd_t;

  typedef struct packed {
    logic take;
    logic have_center;
  } bbe_stat_t;

endpackage

FILE: hw/rtl/bbe_ctrl.sv
module bbe_ctrl import bbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bbe_stat_t stat,
  output bbe_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        row_r, row_nxt;
  logic [QIDX_W-1:0] bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    cmd           = '0;
    cmd.latch     = accept;
    cmd.row       = row_r;
    cmd.bit_idx   = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.take) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.shift = 1'b1;
        row_nxt   = 2'd0;
        state_nxt = stat.have_center ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.acc_en = 1'b1;
        row_nxt    = row_r + 2'd1;
        if (row_r == 2'd2) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        bit_nxt      = QIDX_W'(QBITS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/bbe_dp.sv
module bbe_dp import bbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bbe_cmd_t              cmd,
  output bbe_stat_t             stat,
  input  logic                  in_operation,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_frame_last
);

  logic [XW-1:0]    eff_w_r;
  logic [HGT_W-1:0] eff_h_r;
  logic [COL_W-1:0] x_r;
  logic [HGT_W-1:0] y_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] rd_old_r, rd_new_r;
  logic [PIX_W-1:0] older_mem [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] newer_mem [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] win_r [0:2][0:2];
  logic [HGT_W-1:0] cr_r, cr_nxt;
  logic [COL_W-1:0] cc_r, cc_nxt;
  logic [SUM_W-1:0] acc_r [0:2];
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r [0:2];
  logic [QBITS-1:0] q_r [0:2];
  logic [DEN_W-1:0] den_r;
  logic [CH_W-1:0]  res_r [0:2];
  logic             last_r;

  logic             restart;
  logic             cfg_hit;
  logic             have_nxt;
  logic [XW-1:0]    x_inc;
  logic [XW-1:0]    cfg_w;
  logic [HGT_W-1:0] cfg_h;
  logic             frame_last;
  logic [2:0]       col_ok;
  logic             row_ok;
  logic [PIX_W-1:0] sel_row [0:2];
  logic [SUM_W-1:0] row_sum [0:2];
  logic [NUM_W-1:0] den_sh;

  // effective frame size, saturated at the write
  always_comb begin
    cfg_w = XW'(cfg_wdata[WID_W-1:0]);
    if (cfg_wdata[WID_W-1:0] == '0) begin
      cfg_w = XW'(1);
    end else if (32'(cfg_wdata[WID_W-1:0]) > MAX_WIDTH) begin
      cfg_w = XW'(MAX_WIDTH);
    end
    cfg_h = cfg_wdata[HGT_W-1:0];
    if (cfg_wdata[HGT_W-1:0] == '0) begin
      cfg_h = HGT_W'(1);
    end else if (32'(cfg_wdata[HGT_W-1:0]) > HEIGHT_CAP) begin
      cfg_h = HGT_W'(HEIGHT_CAP);
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_WIDTH:  cfg_hit = cfg_we;
      REG_HEIGHT: cfg_hit = cfg_we;
      default:    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= XW'(1);
      eff_h_r <= HGT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  eff_w_r <= cfg_w;
        REG_HEIGHT: eff_h_r <= cfg_h;
        default: ;
      endcase
    end
  end

  assign frame_last = (cr_r == eff_h_r - 1'b1) && (cc_r == COL_W'(eff_w_r - 1'b1));
  assign restart    = cfg_hit || (cmd.out_load && frame_last);

  // centre pixel sits one row plus one pixel behind the stream position
  always_comb begin
    // a pixel is taken only while the frame expects pixels, a flush only after
    stat.take = (in_operation == OP_PIXEL) ? (y_r < eff_h_r) : (y_r >= eff_h_r);
    if (x_r != '0) begin
      have_nxt = (y_r != '0);
      cr_nxt   = y_r - 1'b1;
      cc_nxt   = x_r - 1'b1;
    end else begin
      have_nxt = (y_r >= HGT_W'(2));
      cr_nxt   = y_r - HGT_W'(2);
      cc_nxt   = COL_W'(eff_w_r - 1'b1);
    end
    stat.have_center = have_nxt && (cr_nxt < eff_h_r);
    x_inc = XW'(x_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix_r <= (in_operation == OP_PIXEL) ? {in_red, in_green, in_blue} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) older_mem[x_r] <= rd_new_r;
    rd_old_r <= older_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) newer_mem[x_r] <= pix_r;
    rd_new_r <= newer_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r <= '0;
      y_r <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_old_r;
      win_r[1][2] <= rd_new_r;
      win_r[2][2] <= pix_r;
      if (x_inc >= eff_w_r) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= COL_W'(x_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      cr_r <= cr_nxt;
      cc_r <= cc_nxt;
    end
  end

  // masked sum of one window row per cycle; neighbours off the frame drop out
  always_comb begin
    col_ok[0] = (cc_r != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = ((XW'(cc_r) + 1'b1) < eff_w_r);
    row_ok = !((cmd.row == 2'd0) && (cr_r == '0)) &&
             !((cmd.row == 2'd2) && ((cr_r + 1'b1) >= eff_h_r));
    for (int c = 0; c < 3; c++) begin
      case (cmd.row)
        2'd0:    sel_row[c] = win_r[0][c];
        2'd1:    sel_row[c] = win_r[1][c];
        default: sel_row[c] = win_r[2][c];
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = acc_r[k];
      for (int c = 0; c < 3; c++) begin
        if (col_ok[c]) begin
          row_sum[k] = row_sum[k] + SUM_W'(sel_row[c][(2-k)*CH_W +: CH_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) acc_r[k] <= '0;
    end else if (cmd.acc_en && row_ok) begin
      cnt_r <= cnt_r + CNT_W'($countones(col_ok));
      for (int k = 0; k < 3; k++) acc_r[k] <= row_sum[k];
    end
  end

  // restoring divide, one quotient bit per cycle in each lane
  assign den_sh = NUM_W'(den_r) << cmd.bit_idx;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_r <= {cnt_r, 1'b0};
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= NUM_W'({acc_r[k], 1'b0}) + NUM_W'(cnt_r);
        q_r[k]   <= '0;
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (rem_r[k] >= den_sh) begin
          rem_r[k]             <= rem_r[k] - den_sh;
          q_r[k][cmd.bit_idx]  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < 3; k++) res_r[k] <= q_r[k];
      last_r <= frame_last;
    end
  end

  assign out_red        = res_r[0];
  assign out_green      = res_r[1];
  assign out_blue       = res_r[2];
  assign out_frame_last = last_r;

endmodule

FILE: hw/rtl/box_blur_3x3_edge_average.sv
// 3x3 box blur over an RGB raster stream, averaging only the neighbours that
// lie inside the frame and rounding half up. One item is in work at a time.
// An item that is dropped (a pixel after the frame is complete, or a flush
// while pixels are still due) is only accepted; an item that yields no result
// goes through accept, then the line-store read/write and window shift; an
// item that yields a result goes through accept, line-store access, summing
// the three window rows in turn, divider setup, the restoring divider (one
// quotient bit per cycle, all three channels in parallel) and the load into
// the output register, plus any wait for that register to drain. Results come
// one row plus one pixel behind the input; after the last pixel send
// image_width+1 flush items, and the final result carries out_frame_last. A
// write to the width or height register restarts the frame.
module box_blur_3x3_edge_average import bbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  out_frame_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  bbe_cmd_t  cmd;
  bbe_stat_t stat;

  bbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

FILE: tb/sv/tb_box_blur_3x3_edge_average.sv
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_average;
  import bbe_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 440;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            last;
  } blur_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    logic [CH_W-1:0]       r;
    logic [CH_W-1:0]       g;
    logic [CH_W-1:0]       b;
    bit                    typed;
    blur_t                 want;
  } plan_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PULSED} rx_mode_t;

  localparam blur_t SINGLE_END = '{r: 8'd255, g: 8'd0, b: 8'd128, last: 1'b1};
  localparam blur_t QUAD_MID   = '{r: 8'd64, g: 8'd0, b: 8'd1, last: 1'b0};
  localparam blur_t QUAD_END   = '{r: 8'd64, g: 8'd0, b: 8'd1, last: 1'b1};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [CH_W-1:0]       in_red;
  logic [CH_W-1:0]       in_green;
  logic [CH_W-1:0]       in_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  out_frame_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  box_blur_3x3_edge_average dut (.*);

  // blur predictor state
  logic [PIX_W-1:0] line_old [MAX_WIDTH];
  logic [PIX_W-1:0] line_new [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [WID_W-1:0] wid_reg;
  logic [HGT_W-1:0] hgt_reg;

  blur_t     blurred_q[$];
  plan_row_t plan[$];

  int unsigned cycles;
  int unsigned n_bad;
  int unsigned n_items;
  int unsigned n_dropped;
  int unsigned n_results;
  int unsigned n_frames;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, blurred_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    if (wid_reg == 0) return 1;
    if (wid_reg > MAX_WIDTH) return MAX_WIDTH;
    return wid_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (hgt_reg == 0) return 1;
    if (hgt_reg > HEIGHT_CAP) return HEIGHT_CAP;
    return hgt_reg;
  endfunction

  function automatic void blur_restart();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void blur_reset();
    wid_reg = WID_W'(1);
    hgt_reg = HGT_W'(1);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    blur_restart();
  endfunction

  // Advance the predictor by one accepted item; returns 1 when it yields a result.
  function automatic bit blur_predict(input logic op, input logic [CH_W-1:0] r, g, b,
                                      output blur_t res, output bit dropped);
    int unsigned w, h, x, y, cr, cc, cnt, s_r, s_g, s_b;
    logic [PIX_W-1:0] pix, v;
    bit centered;
    w = eff_w();
    h = eff_h();
    x = col_pos;
    y = row_pos;
    pix = '0;
    res = '0;
    dropped = 1'b1;
    if (op == OP_PIXEL) begin
      if (y >= h) return 1'b0;
      pix = {r, g, b};
    end else if (y < h) begin
      return 1'b0;
    end
    dropped = 1'b0;
    if (x >= MAX_WIDTH) x = 0;

    for (int dr = 0; dr < 3; dr++) begin
      win[dr][0] = win[dr][1];
      win[dr][1] = win[dr][2];
    end
    win[0][2] = line_old[x];
    win[1][2] = line_new[x];
    win[2][2] = pix;
    line_old[x] = line_new[x];
    line_new[x] = pix;

    // center sits one row plus one pixel behind the stream position
    if (x >= 1) begin
      centered = (y >= 1);
      cr = y - 1;
      cc = x - 1;
    end else begin
      centered = (y >= 2);
      cr = y - 2;
      cc = w - 1;
    end

    x++;
    if (x >= w) begin
      x = 0;
      y++;
    end
    col_pos = x;
    row_pos = y;

    if (!centered || cr >= h) return 1'b0;

    s_r = 0;
    s_g = 0;
    s_b = 0;
    cnt = 0;
    for (int dr = 0; dr < 3; dr++) begin
      if (dr == 0 && cr == 0) continue;
      if (dr == 2 && cr + 1 >= h) continue;
      for (int dc = 0; dc < 3; dc++) begin
        if (dc == 0 && cc == 0) continue;
        if (dc == 2 && cc + 1 >= w) continue;
        v = win[dr][dc];
        s_r += v[23:16];
        s_g += v[15:8];
        s_b += v[7:0];
        cnt++;
      end
    end
    res.r = CH_W'((2 * s_r + cnt) / (2 * cnt));
    res.g = CH_W'((2 * s_g + cnt) / (2 * cnt));
    res.b = CH_W'((2 * s_b + cnt) / (2 * cnt));
    res.last = (cr == h - 1 && cc == w - 1);
    if (res.last) blur_restart();
    return 1'b1;
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [CH_W-1:0] r, g, b,
                                         input bit typed = 1'b0, input blur_t want = '0);
    plan_row_t row;
    row = '{default: '0};
    row.op = op;
    row.r = r;
    row.g = g;
    row.b = b;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_item(input logic op, input logic [CH_W-1:0] r, g, b,
                           input bit typed = 1'b0, input blur_t want = '0);
    blur_t res;
    bit has, dropped;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= op;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    has = blur_predict(op, r, g, b, res, dropped);
    if (typed) blurred_q.push_back(want);
    else if (has) blurred_q.push_back(res);
    n_items++;
    if (dropped) n_dropped++;
    @(negedge clk);
  endtask

  // Hold the sender until every due result is out, then wait extra cycles.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH: begin
        wid_reg = val[WID_W-1:0];
        blur_restart();
      end
      REG_HEIGHT: begin
        hgt_reg = val[HGT_W-1:0];
        blur_restart();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_frame(input int unsigned nw, nh, input bit noisy, input bit want_cut,
                           output bit was_cut);
    int unsigned total, stop;
    total = nw * nh;
    stop = (want_cut && total > 1) ? $urandom_range(1, total - 1) : total;
    was_cut = (stop < total);
    for (int unsigned i = 0; i < stop; i++) begin
      // early flush, dropped by the block
      if (noisy && $urandom_range(0, 39) == 0)
        push_item(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
      if (noisy && $urandom_range(0, 59) == 0) drain(0);
      push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    if (!was_cut) begin
      for (int unsigned i = 0; i <= nw; i++) begin
        // late pixel while draining, dropped by the block
        if (noisy && $urandom_range(0, 39) == 0)
          push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
        push_item(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    blur_t got, want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = '{r: out_red, g: out_green, b: out_blue, last: out_frame_last};
      n_results++;
      if (got.last === 1'b1) n_frames++;
      if (blurred_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d last=%0d", got.r, got.g, got.b,
                   got.last);
      end else begin
        want = blurred_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                     n_results, want.r, want.g, want.b, want.last,
                     got.r, got.g, got.b, got.last);
        end
      end
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int unsigned span, phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(64, 256);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_PULSED: out_ready <= ((phase % 11) < 4);
          default:   out_ready <= 1'b1;
        endcase
        phase++;
      end
    end
  end

  initial begin : stimulus
    int unsigned start, wv, hv;
    bit cut, fresh, was_cut;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_PIXEL;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    cycles = 0;
    n_bad = 0;
    n_items = 0;
    n_dropped = 0;
    n_results = 0;
    n_frames = 0;
    burst_left = 0;
    blur_reset();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // one-pixel frame at reset geometry, with dropped items around it
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(OP_PIXEL, 8'hFF, 8'h00, 8'h80));
    plan.push_back(item_row(OP_PIXEL, 8'h12, 8'h34, 8'h56));
    plan.push_back(item_row(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, SINGLE_END));
    // 2x2 frame: every pixel sees all four, blue rounds half up
    plan.push_back(cfg_row(REG_WIDTH, 13'd2));
    plan.push_back(cfg_row(REG_HEIGHT, 13'd2));
    plan.push_back(item_row(OP_PIXEL, 8'hFF, 8'h00, 8'h02));
    plan.push_back(item_row(OP_PIXEL, 8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(OP_PIXEL, 8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(OP_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, QUAD_MID));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, QUAD_MID));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, QUAD_MID));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1, QUAD_END));
    // zero width acts as one; early flush mid-frame
    plan.push_back(cfg_row(REG_WIDTH, 13'd0));
    plan.push_back(cfg_row(REG_HEIGHT, 13'd3));
    plan.push_back(item_row(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(OP_PIXEL, 8'hFF, 8'h01, 8'h00));
    plan.push_back(item_row(OP_PIXEL, 8'h00, 8'h80, 8'h7F));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    // writes to unused indexes mid-frame must not restart it
    plan.push_back(cfg_row(REG_WIDTH, 13'd3));
    plan.push_back(cfg_row(REG_HEIGHT, 13'd1));
    plan.push_back(item_row(OP_PIXEL, 8'h10, 8'hEF, 8'hFF));
    plan.push_back(cfg_row(REG_SPARE_A, 13'h1FFF));
    plan.push_back(item_row(OP_PIXEL, 8'hFE, 8'h01, 8'h00));
    plan.push_back(cfg_row(REG_SPARE_B, 13'h0000));
    plan.push_back(item_row(OP_PIXEL, 8'h55, 8'hAA, 8'h03));
    for (int i = 0; i < 4; i++)
      plan.push_back(item_row(OP_FLUSH, 8'h00, 8'h00, 8'h00));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain(SETTLE_CYCLES);
        cfg_write(plan[k].idx, plan[k].data);
      end else begin
        push_item(plan[k].op, plan[k].r, plan[k].g, plan[k].b, plan[k].typed, plan[k].want);
      end
    end

    // random frames of small size, some cut short and restarted
    start = n_items - n_dropped;
    fresh = 1'b1;
    while (n_items - n_dropped - start < RANDOM_ITEMS) begin
      if (fresh || $urandom_range(0, 2) != 0) begin
        drain(SETTLE_CYCLES);
        wv = ($urandom_range(0, 7) == 0) ? 0 :
             ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        hv = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
        case ($urandom_range(0, 2))
          0: cfg_write(REG_WIDTH, CFG_DATA_W'(wv));
          1: cfg_write(REG_HEIGHT, CFG_DATA_W'(hv));
          default: begin
            cfg_write(REG_HEIGHT, CFG_DATA_W'(hv));
            cfg_write(REG_WIDTH, CFG_DATA_W'(wv));
          end
        endcase
      end
      cut = ($urandom_range(0, 7) == 0);
      run_frame(eff_w(), eff_h(), 1'b1, cut, was_cut);
      fresh = was_cut;
    end

    // saturating width and height, checked over the opening rows of a frame
    drain(SETTLE_CYCLES);
    cfg_write(REG_WIDTH, 13'h1FFF);
    cfg_write(REG_HEIGHT, 13'd2);
    for (int i = 0; i < 24; i++)
      push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    drain(SETTLE_CYCLES);
    cfg_write(REG_WIDTH, 13'd3);
    cfg_write(REG_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 30; i++)
      push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());

    drain(40);
    $display("Sent %0d items (%0d dropped by the block), %0d results over %0d frames checked",
             n_items, n_dropped, n_results, n_frames);
    $display("Frames from 1x1 to 16x5, some cut short, plus saturated width and height, %0d mismatches",
             n_bad);
    if (n_bad == 0 && blurred_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
